/* hdl/cau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and defaults for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Default operand width and fraction bits (Q8.8)
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Control that travels with an item down the pipeline
  typedef struct packed {
    op_t  op;
    logic dz;
    logic neg_re;
    logic neg_im;
  } ctl_t;

endpackage

/* hdl/cau_prod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_prod
// First stage: the six operand products and the add/subtract sums.
// ----------------------------------------------------------------------------
module cau_prod #(
  parameter int DW = cau_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   i_valid,
  input  cau_pkg::op_t           i_op,
  input  logic signed [DW-1:0]   i_a_re,
  input  logic signed [DW-1:0]   i_a_im,
  input  logic signed [DW-1:0]   i_b_re,
  input  logic signed [DW-1:0]   i_b_im,
  output logic                   o_valid_r,
  output cau_pkg::op_t           o_op_r,
  output logic signed [2*DW-1:0] o_rr_r,
  output logic signed [2*DW-1:0] o_ii_r,
  output logic signed [2*DW-1:0] o_ir_r,
  output logic signed [2*DW-1:0] o_ri_r,
  output logic [2*DW-1:0]        o_br2_r,
  output logic [2*DW-1:0]        o_bi2_r,
  output logic signed [DW:0]     o_s_re_r,
  output logic signed [DW:0]     o_s_im_r
);

  logic signed [2*DW-1:0] br2_nxt;
  logic signed [2*DW-1:0] bi2_nxt;
  logic signed [DW:0]     s_re_nxt;
  logic signed [DW:0]     s_im_nxt;

  // Squares of the divisor parts are never negative
  assign br2_nxt = i_b_re * i_b_re;
  assign bi2_nxt = i_b_im * i_b_im;

  // Sum or difference, one bit wider than the operands
  always_comb begin
    if (i_op == cau_pkg::OP_SUB) begin
      s_re_nxt = (DW+1)'(i_a_re) - (DW+1)'(i_b_re);
      s_im_nxt = (DW+1)'(i_a_im) - (DW+1)'(i_b_im);
    end else begin
      s_re_nxt = (DW+1)'(i_a_re) + (DW+1)'(i_b_re);
      s_im_nxt = (DW+1)'(i_a_im) + (DW+1)'(i_b_im);
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= i_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      o_op_r   <= i_op;
      o_rr_r   <= i_a_re * i_b_re;
      o_ii_r   <= i_a_im * i_b_im;
      o_ir_r   <= i_a_im * i_b_re;
      o_ri_r   <= i_a_re * i_b_im;
      o_br2_r  <= unsigned'(br2_nxt);
      o_bi2_r  <= unsigned'(bi2_nxt);
      o_s_re_r <= s_re_nxt;
      o_s_im_r <= s_im_nxt;
    end
  end

endmodule

/* hdl/cau_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_norm
// Second stage: combines products, forms sign and magnitude, the divisor
// and the divide-by-zero flag, and loads the dividend.
// ----------------------------------------------------------------------------
module cau_norm #(
  parameter int DW = cau_pkg::DATA_WIDTH_DEF,
  parameter int FB = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     i_valid,
  input  cau_pkg::op_t             i_op,
  input  logic signed [2*DW-1:0]   i_rr,
  input  logic signed [2*DW-1:0]   i_ii,
  input  logic signed [2*DW-1:0]   i_ir,
  input  logic signed [2*DW-1:0]   i_ri,
  input  logic [2*DW-1:0]          i_br2,
  input  logic [2*DW-1:0]          i_bi2,
  input  logic signed [DW:0]       i_s_re,
  input  logic signed [DW:0]       i_s_im,
  output logic                     o_valid_r,
  output cau_pkg::ctl_t            o_ctl_r,
  output logic [2*DW-1:0]          o_den_r,
  output logic [2*DW+FB-1:0]       o_rem_re_r,
  output logic [2*DW+FB-1:0]       o_rem_im_r
);

  localparam int XW = 2*DW+1;
  localparam int RW = 2*DW+FB;

  logic signed [XW-1:0] x_re;
  logic signed [XW-1:0] x_im;
  logic [XW-1:0]        nx_re;
  logic [XW-1:0]        nx_im;
  logic [2*DW-1:0]      mag_re;
  logic [2*DW-1:0]      mag_im;
  logic [2*DW-1:0]      den_nxt;
  cau_pkg::ctl_t        ctl_nxt;
  logic [RW-1:0]        rem_re_nxt;
  logic [RW-1:0]        rem_im_nxt;

  // Exact real and imaginary values before scaling
  always_comb begin
    unique case (i_op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        x_re = XW'(i_s_re);
        x_im = XW'(i_s_im);
      end
      cau_pkg::OP_MUL: begin
        x_re = XW'(i_rr) - XW'(i_ii);
        x_im = XW'(i_ir) + XW'(i_ri);
      end
      default: begin
        x_re = XW'(i_rr) + XW'(i_ii);
        x_im = XW'(i_ir) - XW'(i_ri);
      end
    endcase
  end

  // Sign and magnitude
  assign nx_re  = -unsigned'(x_re);
  assign nx_im  = -unsigned'(x_im);
  assign mag_re = x_re[XW-1] ? nx_re[2*DW-1:0] : unsigned'(x_re[2*DW-1:0]);
  assign mag_im = x_im[XW-1] ? nx_im[2*DW-1:0] : unsigned'(x_im[2*DW-1:0]);
  assign den_nxt = i_br2 + i_bi2;

  always_comb begin
    ctl_nxt.op     = i_op;
    ctl_nxt.dz     = (i_op == cau_pkg::OP_DIV) && (den_nxt == '0);
    ctl_nxt.neg_re = x_re[XW-1];
    ctl_nxt.neg_im = x_im[XW-1];
    // Divide works on the magnitude scaled up by the fraction bits
    if (i_op == cau_pkg::OP_DIV) begin
      rem_re_nxt = RW'(mag_re) << FB;
      rem_im_nxt = RW'(mag_im) << FB;
    end else begin
      rem_re_nxt = RW'(mag_re);
      rem_im_nxt = RW'(mag_im);
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= i_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      o_ctl_r    <= ctl_nxt;
      o_den_r    <= den_nxt;
      o_rem_re_r <= rem_re_nxt;
      o_rem_im_r <= rem_im_nxt;
    end
  end

endmodule

/* hdl/cau_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_stage
// One restoring division step for both parts: quotient bit at SHIFT.
// Items that are not divides pass their magnitude through untouched.
// ----------------------------------------------------------------------------
module cau_div_stage #(
  parameter int DW    = cau_pkg::DATA_WIDTH_DEF,
  parameter int FB    = cau_pkg::FRAC_BITS_DEF,
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 i_valid,
  input  cau_pkg::ctl_t        i_ctl,
  input  logic [2*DW-1:0]      i_den,
  input  logic [2*DW+FB-1:0]   i_rem_re,
  input  logic [2*DW+FB-1:0]   i_rem_im,
  input  logic [DW+1:0]        i_q_re,
  input  logic [DW+1:0]        i_q_im,
  output logic                 o_valid_r,
  output cau_pkg::ctl_t        o_ctl_r,
  output logic [2*DW-1:0]      o_den_r,
  output logic [2*DW+FB-1:0]   o_rem_re_r,
  output logic [2*DW+FB-1:0]   o_rem_im_r,
  output logic [DW+1:0]        o_q_re_r,
  output logic [DW+1:0]        o_q_im_r
);

  localparam int RW = 2*DW+FB;

  logic          is_div;
  logic          ge_re;
  logic          ge_im;
  logic [RW-1:0] den_sh;
  logic [RW-1:0] rem_re_nxt;
  logic [RW-1:0] rem_im_nxt;

  // Compare against the shifted divisor without widening the remainder
  assign is_div = (i_ctl.op == cau_pkg::OP_DIV);
  assign den_sh = RW'(i_den) << SHIFT;
  assign ge_re  = (i_rem_re >> SHIFT) >= RW'(i_den);
  assign ge_im  = (i_rem_im >> SHIFT) >= RW'(i_den);

  assign rem_re_nxt = (is_div && ge_re) ? i_rem_re - den_sh : i_rem_re;
  assign rem_im_nxt = (is_div && ge_im) ? i_rem_im - den_sh : i_rem_im;

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= i_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      o_ctl_r    <= i_ctl;
      o_den_r    <= i_den;
      o_rem_re_r <= rem_re_nxt;
      o_rem_im_r <= rem_im_nxt;
      o_q_re_r   <= {i_q_re[DW:0], ge_re};
      o_q_im_r   <= {i_q_im[DW:0], ge_im};
    end
  end

endmodule

/* hdl/cau_sat.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_sat
// Last stage: floor shift of products, selection of the quotient,
// saturation to the output width and the output register.
// ----------------------------------------------------------------------------
module cau_sat #(
  parameter int DW = cau_pkg::DATA_WIDTH_DEF,
  parameter int FB = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 i_valid,
  input  cau_pkg::ctl_t        i_ctl,
  input  logic [2*DW+FB-1:0]   i_rem_re,
  input  logic [2*DW+FB-1:0]   i_rem_im,
  input  logic [DW+1:0]        i_q_re,
  input  logic [DW+1:0]        i_q_im,
  output logic                 o_valid_r,
  output logic signed [DW-1:0] o_re_r,
  output logic signed [DW-1:0] o_im_r,
  output logic                 o_ovf_r,
  output logic                 o_dz_r
);

  localparam int VW = 2*DW;
  localparam int MS = (FB >= VW) ? 0 : VW - FB;
  localparam logic [VW-1:0] LOW_MASK = (FB >= VW) ? {VW{1'b1}} : ({VW{1'b1}} >> MS);
  localparam logic [VW-1:0] HALF = VW'(1) << (DW-1);

  // Clamp a sign-magnitude value; returns {overflow, field bits}
  function automatic logic [DW:0] sat_fn(input logic neg, input logic [VW-1:0] v);
    logic [VW-1:0] nv;
    logic [VW-1:0] hm;
    nv = -v;
    hm = HALF - VW'(1);
    if (neg) begin
      if (v > HALF) begin
        sat_fn = {1'b1, HALF[DW-1:0]};
      end else begin
        sat_fn = {1'b0, nv[DW-1:0]};
      end
    end else begin
      if (v > hm) begin
        sat_fn = {1'b1, hm[DW-1:0]};
      end else begin
        sat_fn = {1'b0, v[DW-1:0]};
      end
    end
  endfunction

  logic [VW-1:0] mag_re;
  logic [VW-1:0] mag_im;
  logic [VW-1:0] v_re;
  logic [VW-1:0] v_im;
  logic [DW:0]   sr;
  logic [DW:0]   si;
  logic [DW-1:0] re_nxt;
  logic [DW-1:0] im_nxt;
  logic          ovf_nxt;

  assign mag_re = i_rem_re[VW-1:0];
  assign mag_im = i_rem_im[VW-1:0];

  // Magnitude to saturate, per operation
  always_comb begin
    unique case (i_ctl.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        v_re = mag_re;
        v_im = mag_im;
      end
      cau_pkg::OP_MUL: begin
        // Round toward minus infinity: bump negative values with a remainder
        v_re = (mag_re >> FB) + VW'(i_ctl.neg_re && ((mag_re & LOW_MASK) != '0));
        v_im = (mag_im >> FB) + VW'(i_ctl.neg_im && ((mag_im & LOW_MASK) != '0));
      end
      default: begin
        v_re = VW'(i_q_re);
        v_im = VW'(i_q_im);
      end
    endcase
  end

  assign sr = sat_fn(i_ctl.neg_re, v_re);
  assign si = sat_fn(i_ctl.neg_im, v_im);

  // A zero divisor forces a clean zero result
  always_comb begin
    if (i_ctl.dz) begin
      re_nxt  = '0;
      im_nxt  = '0;
      ovf_nxt = 1'b0;
    end else begin
      re_nxt  = sr[DW-1:0];
      im_nxt  = si[DW-1:0];
      ovf_nxt = sr[DW] | si[DW];
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= i_valid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      o_re_r  <= signed'(re_nxt);
      o_im_r  <= signed'(im_nxt);
      o_ovf_r <= ovf_nxt;
      o_dz_r  <= i_ctl.dz;
    end
  end

endmodule

/* hdl/complex_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply and divide in signed fixed point.
// ----------------------------------------------------------------------------
// Accepts one item every cycle while in_stall is low. Each result comes
// from one product stage, one combine stage, DATA_WIDTH+2 restoring
// division steps that every item passes through so that all operations
// share one latency, and a saturating output register.
// The whole pipeline, empty slots included, holds while out_stall is high
// with a result waiting; in_stall follows it in the same cycle. While the
// output register is empty the pipeline moves whatever out_stall says.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic                         out_overflow,
  output logic                         out_div_by_zero
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int RW = 2*DW+FB;
  localparam int NS = DW+2;

  logic adv;

  // Stage A outputs
  logic                   a_valid;
  cau_pkg::op_t           a_op;
  logic signed [2*DW-1:0] a_rr;
  logic signed [2*DW-1:0] a_ii;
  logic signed [2*DW-1:0] a_ir;
  logic signed [2*DW-1:0] a_ri;
  logic [2*DW-1:0]        a_br2;
  logic [2*DW-1:0]        a_bi2;
  logic signed [DW:0]     a_s_re;
  logic signed [DW:0]     a_s_im;

  // Division chain, index 0 is the combine stage
  logic            d_valid  [0:NS];
  cau_pkg::ctl_t   d_ctl    [0:NS];
  logic [2*DW-1:0] d_den    [0:NS];
  logic [RW-1:0]   d_rem_re [0:NS];
  logic [RW-1:0]   d_rem_im [0:NS];
  logic [DW+1:0]   d_q_re   [0:NS];
  logic [DW+1:0]   d_q_im   [0:NS];

  // Whole pipeline moves unless a finished result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  cau_prod #(.DW(DW)) u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .i_valid   (in_valid),
    .i_op      (cau_pkg::op_t'(in_req_type)),
    .i_a_re    (in_a_re),
    .i_a_im    (in_a_im),
    .i_b_re    (in_b_re),
    .i_b_im    (in_b_im),
    .o_valid_r (a_valid),
    .o_op_r    (a_op),
    .o_rr_r    (a_rr),
    .o_ii_r    (a_ii),
    .o_ir_r    (a_ir),
    .o_ri_r    (a_ri),
    .o_br2_r   (a_br2),
    .o_bi2_r   (a_bi2),
    .o_s_re_r  (a_s_re),
    .o_s_im_r  (a_s_im)
  );

  cau_norm #(.DW(DW), .FB(FB)) u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .i_valid    (a_valid),
    .i_op       (a_op),
    .i_rr       (a_rr),
    .i_ii       (a_ii),
    .i_ir       (a_ir),
    .i_ri       (a_ri),
    .i_br2      (a_br2),
    .i_bi2      (a_bi2),
    .i_s_re     (a_s_re),
    .i_s_im     (a_s_im),
    .o_valid_r  (d_valid[0]),
    .o_ctl_r    (d_ctl[0]),
    .o_den_r    (d_den[0]),
    .o_rem_re_r (d_rem_re[0]),
    .o_rem_im_r (d_rem_im[0])
  );

  // Quotient starts empty; bits shift in from the top step down
  assign d_q_re[0] = '0;
  assign d_q_im[0] = '0;

  // One step per quotient bit, highest bit first; the top bit marks range
  for (genvar k = 0; k < NS; k++) begin : g_div
    cau_div_stage #(.DW(DW), .FB(FB), .SHIFT(NS-1-k)) u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .i_valid    (d_valid[k]),
      .i_ctl      (d_ctl[k]),
      .i_den      (d_den[k]),
      .i_rem_re   (d_rem_re[k]),
      .i_rem_im   (d_rem_im[k]),
      .i_q_re     (d_q_re[k]),
      .i_q_im     (d_q_im[k]),
      .o_valid_r  (d_valid[k+1]),
      .o_ctl_r    (d_ctl[k+1]),
      .o_den_r    (d_den[k+1]),
      .o_rem_re_r (d_rem_re[k+1]),
      .o_rem_im_r (d_rem_im[k+1]),
      .o_q_re_r   (d_q_re[k+1]),
      .o_q_im_r   (d_q_im[k+1])
    );
  end

  cau_sat #(.DW(DW), .FB(FB)) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .i_valid   (d_valid[NS]),
    .i_ctl     (d_ctl[NS]),
    .i_rem_re  (d_rem_re[NS]),
    .i_rem_im  (d_rem_im[NS]),
    .i_q_re    (d_q_re[NS]),
    .i_q_im    (d_q_im[NS]),
    .o_valid_r (out_valid),
    .o_re_r    (out_res_re),
    .o_im_r    (out_res_im),
    .o_ovf_r   (out_overflow),
    .o_dz_r    (out_div_by_zero)
  );

`ifndef SYNTHESIS
  // Zero divisor gives a clean zero result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> out_res_re == '0 && out_res_im == '0 && !out_overflow)
    else $error("divide by zero result not cleared");

  // The zero-divisor flag only rides on divides
  assert property (@(posedge clk) disable iff (!rst_n)
    d_valid[NS] && d_ctl[NS].dz |-> d_ctl[NS].op == cau_pkg::OP_DIV)
    else $error("zero divisor flag on a non-divide");

  // A held result freezes the last stage's input
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(d_valid[NS]) && $stable(d_ctl[NS]))
    else $error("pipeline moved while held");

  // Saturation shows an extreme value in at least one part
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_res_re[DW-1] != out_res_re[DW-2] || out_res_im[DW-1] != out_res_im[DW-2] ||
      out_res_re == {1'b1, {(DW-1){1'b0}}} || out_res_re == {1'b0, {(DW-1){1'b1}}} ||
      out_res_im == {1'b1, {(DW-1){1'b0}}} || out_res_im == {1'b0, {(DW-1){1'b1}}})
    else $error("overflow without a clamped part");
`endif

endmodule
